// ===== design/rssc_pkg.sv =====
// shared types and constants for the range sum of squared counts block
// no dependencies

package rssc_pkg;

   localparam int ARRAY_DEPTH_DEFAULT = 131072;
   localparam int VALUE_COUNT_DEFAULT = 131072;
   localparam int QUEUE_DEPTH         = 2;

   localparam int FIELD_W    = 17;
   localparam int LEN_W      = 18;
   localparam int COUNT_W    = 18;
   localparam int SUM_W      = 35;
   localparam int KIND_W     = 2;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 40;

   localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_QUERY,
      CMD_BAD,
      CMD_CLEAR
   } cmd_op_type;

   // load: a = position, b = value; query: a = left, b = right
   typedef struct packed {
      cmd_op_type         op;
      logic [FIELD_W-1:0] a;
      logic [FIELD_W-1:0] b;
   } cmd_type;

endpackage

// ===== design/range_sum_of_squared_counts.sv =====
// top level of the range sum of squared counts block
// depends on rssc_pkg, rssc_front, rssc_queue, rssc_back
//
// Requests arrive on req_ (kind in req_tuser): a load writes one array element
// while the window is empty, a query returns the sum over distinct values of the
// squared count of each value in positions left..right, a clear empties the window.
// Each query gives one response on rsp_; bad_range (rsp_tuser) is set with a zero
// sum when left > right or right is at or past array_length or ARRAY_DEPTH. Loads and
// clears give no response. array_length is written on the csr_ channel; the user must
// write it only while idle, and the block does not enforce this. A load is done in the
// idle state; a query walks the window one position added or removed at a time through
// the read, read, update walk of the array memory and the count memory; a clear walks
// each window position the same way. A two-entry queue lets requests be taken while the
// engine walks, and the response register lets the engine finish the next request while
// a response waits. After reset the count memory is swept to zero, one entry a cycle
// over all VALUE_COUNT entries, with req_tready low. A stalled rsp_tready holds the
// response and, once the queue fills, req_tready.

module range_sum_of_squared_counts
   import rssc_pkg::*;
#(
   parameter int ARRAY_DEPTH = ARRAY_DEPTH_DEFAULT,
   parameter int VALUE_COUNT = VALUE_COUNT_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // position, element_value, range_left, range_right
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // kind
   input  logic [KIND_W-1:0]     req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // square_sum
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // bad_range
   output logic                  rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [LEN_W-1:0]      csr_wdata
);

   logic             back_open;
   logic             queue_full;
   logic             push;
   cmd_type          cmd;
   logic             q_not_empty;
   cmd_type          q_head;
   logic             q_pop;
   logic [SUM_W-1:0] rsp_sum;

   rssc_front #(
      .ARRAY_DEPTH(ARRAY_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .back_open  (back_open),
      .queue_full (queue_full),
      .push       (push),
      .cmd        (cmd)
   );

   rssc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (cmd),
      .full      (queue_full),
      .not_empty (q_not_empty),
      .pop       (q_pop),
      .head      (q_head)
   );

   rssc_back #(
      .ARRAY_DEPTH(ARRAY_DEPTH),
      .VALUE_COUNT(VALUE_COUNT)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .open        (back_open),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_sum     (rsp_sum),
      .rsp_bad     (rsp_tuser)
   );

   assign rsp_tdata = {(RSP_DATA_W - SUM_W)'(0), rsp_sum};

endmodule

// ===== design/rssc_front.sv =====
// request intake: classifies requests, checks ranges, holds array_length
// depends on rssc_pkg

module rssc_front
   import rssc_pkg::*;
#(
   parameter int ARRAY_DEPTH = ARRAY_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [KIND_W-1:0]     req_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [LEN_W-1:0]      csr_wdata,
   input  logic                  back_open,
   input  logic                  queue_full,
   output logic                  push,
   output cmd_type               cmd
);

   logic [LEN_W-1:0]   len_ff;
   logic [LEN_W-1:0]   len_in;
   logic [FIELD_W-1:0] position;
   logic [FIELD_W-1:0] element_value;
   logic [FIELD_W-1:0] range_left;
   logic [FIELD_W-1:0] range_right;
   logic               keep;
   logic               bad;

   assign position      = req_tdata[16:0];
   assign element_value = req_tdata[33:17];
   assign range_left    = req_tdata[50:34];
   assign range_right   = req_tdata[67:51];

   assign csr_ready  = 1'b1;
   assign req_tready = back_open && !queue_full;
   assign push       = req_tvalid && req_tready && keep;

   assign bad = (range_left > range_right) || ({1'b0, range_right} >= len_ff) ||
                (int'(range_right) >= ARRAY_DEPTH);

   always_comb begin
      keep   = 1'b0;
      cmd.op = CMD_LOAD;
      cmd.a  = position;
      cmd.b  = element_value;
      case (req_tuser)
         KIND_LOAD: begin
            keep = int'(position) < ARRAY_DEPTH;
         end
         KIND_QUERY: begin
            keep   = 1'b1;
            cmd.op = bad ? CMD_BAD : CMD_QUERY;
            cmd.a  = range_left;
            cmd.b  = range_right;
         end
         KIND_CLEAR: begin
            keep   = 1'b1;
            cmd.op = CMD_CLEAR;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   always_comb begin
      len_in = len_ff;
      if (csr_valid && csr_ready) begin
         len_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else begin
         len_ff <= len_in;
      end
   end

endmodule

// ===== design/rssc_queue.sv =====
// short command queue between intake and window engine
// depends on rssc_pkg

module rssc_queue
   import rssc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   output logic    not_empty,
   input  logic    pop,
   output cmd_type head
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   cmd_type         entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff;
   logic [PW-1:0]   wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff;
   logic [PW-1:0]   rd_ptr_in;
   logic [CW-1:0]   fill_ff;
   logic [CW-1:0]   fill_in;

   assign full      = fill_ff == CW'(QUEUE_DEPTH);
   assign not_empty = fill_ff != '0;
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + CW'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== design/rssc_back.sv =====
// window engine: array and count memories, window walk, running sum, response register
// depends on rssc_pkg

module rssc_back
   import rssc_pkg::*;
#(
   parameter int ARRAY_DEPTH = ARRAY_DEPTH_DEFAULT,
   parameter int VALUE_COUNT = VALUE_COUNT_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   output logic             open,
   input  logic             q_not_empty,
   input  cmd_type          q_head,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [SUM_W-1:0] rsp_sum,
   output logic             rsp_bad
);

   localparam int AW = $clog2(ARRAY_DEPTH);
   localparam int VW = $clog2(VALUE_COUNT);

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_PLAN,
      S_CREAD,
      S_UPD,
      S_RESULT
   } state_type;

   state_type          state_ff, state_in;
   logic [VW-1:0]      init_addr_ff, init_addr_in;
   logic               empty_ff, empty_in;
   logic               clr_ff, clr_in;
   logic               last_ff, last_in;
   logic               drop_ff, drop_in;
   logic               bad_ff, bad_in;
   logic [FIELD_W-1:0] wl_ff, wl_in;
   logic [FIELD_W-1:0] wr_ff, wr_in;
   logic [FIELD_W-1:0] l_ff, l_in;
   logic [FIELD_W-1:0] r_ff, r_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]   rsp_sum_ff, rsp_sum_in;
   logic               rsp_bad_ff, rsp_bad_in;

   logic [VW-1:0]      array_mem [ARRAY_DEPTH];
   logic [COUNT_W-1:0] count_mem [VALUE_COUNT];

   logic               arr_we, arr_re;
   logic [AW-1:0]      arr_waddr, arr_raddr;
   logic [VW-1:0]      arr_wdata, arr_q;
   logic               cnt_we, cnt_re;
   logic [VW-1:0]      cnt_waddr, cnt_raddr;
   logic [COUNT_W-1:0] cnt_wdata, cnt_q;
   logic [VW-1:0]      bin_ff, bin_in;
   logic [FIELD_W-1:0] step_pos;
   logic               step_go;

   assign open      = state_ff != S_INIT;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_sum   = rsp_sum_ff;
   assign rsp_bad   = rsp_bad_ff;

   always_comb begin
      state_in     = state_ff;
      init_addr_in = init_addr_ff;
      empty_in     = empty_ff;
      clr_in       = clr_ff;
      last_in      = last_ff;
      drop_in      = drop_ff;
      bad_in       = bad_ff;
      wl_in        = wl_ff;
      wr_in        = wr_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      sum_in       = sum_ff;
      bin_in       = bin_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_sum_in   = rsp_sum_ff;
      rsp_bad_in   = rsp_bad_ff;
      q_pop        = 1'b0;
      arr_we       = 1'b0;
      arr_re       = 1'b0;
      arr_waddr    = AW'(q_head.a);
      arr_wdata    = (int'(q_head.b) >= VALUE_COUNT) ? VW'(VALUE_COUNT - 1) : VW'(q_head.b);
      arr_raddr    = '0;
      cnt_we       = 1'b0;
      cnt_re       = 1'b0;
      cnt_waddr    = bin_ff;
      cnt_wdata    = '0;
      cnt_raddr    = arr_q;
      step_pos     = wl_ff;
      step_go      = 1'b0;
      case (state_ff)
         S_INIT: begin
            cnt_we    = 1'b1;
            cnt_waddr = init_addr_ff;
            if (init_addr_ff == VW'(VALUE_COUNT - 1)) begin
               state_in = S_IDLE;
            end else begin
               init_addr_in = init_addr_ff + VW'(1);
            end
         end
         S_IDLE: begin
            if (q_not_empty) begin
               q_pop = 1'b1;
               case (q_head.op)
                  CMD_LOAD: begin
                     arr_we = empty_ff;
                  end
                  CMD_BAD: begin
                     bad_in   = 1'b1;
                     state_in = S_RESULT;
                  end
                  CMD_QUERY: begin
                     bad_in   = 1'b0;
                     clr_in   = 1'b0;
                     l_in     = q_head.a;
                     r_in     = q_head.b;
                     state_in = S_PLAN;
                  end
                  CMD_CLEAR: begin
                     if (empty_ff) begin
                        sum_in = '0;
                        wl_in  = '0;
                        wr_in  = '0;
                     end else begin
                        clr_in   = 1'b1;
                        state_in = S_PLAN;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_PLAN: begin
            step_go = 1'b1;
            last_in = 1'b0;
            if (clr_ff) begin
               step_pos = wl_ff;
               drop_in  = 1'b1;
               last_in  = wl_ff == wr_ff;
               wl_in    = wl_ff + FIELD_W'(1);
            end else if (empty_ff) begin
               step_pos = l_ff;
               drop_in  = 1'b0;
               wl_in    = l_ff;
               wr_in    = l_ff;
               empty_in = 1'b0;
            end else if (wl_ff > l_ff) begin
               step_pos = wl_ff - FIELD_W'(1);
               drop_in  = 1'b0;
               wl_in    = step_pos;
            end else if (wr_ff < r_ff) begin
               step_pos = wr_ff + FIELD_W'(1);
               drop_in  = 1'b0;
               wr_in    = step_pos;
            end else if (wl_ff < l_ff) begin
               step_pos = wl_ff;
               drop_in  = 1'b1;
               wl_in    = wl_ff + FIELD_W'(1);
            end else if (wr_ff > r_ff) begin
               step_pos = wr_ff;
               drop_in  = 1'b1;
               wr_in    = wr_ff - FIELD_W'(1);
            end else begin
               step_go  = 1'b0;
               state_in = S_RESULT;
            end
            if (step_go) begin
               arr_re    = 1'b1;
               arr_raddr = AW'(step_pos);
               state_in  = S_CREAD;
            end
         end
         S_CREAD: begin
            cnt_re    = 1'b1;
            cnt_raddr = arr_q;
            bin_in    = arr_q;
            state_in  = S_UPD;
         end
         S_UPD: begin
            if (drop_ff) begin
               if (cnt_q != '0) begin
                  cnt_we    = 1'b1;
                  cnt_wdata = cnt_q - COUNT_W'(1);
                  sum_in    = sum_ff - SUM_W'({cnt_wdata, 1'b1});
               end
            end else begin
               cnt_we    = 1'b1;
               cnt_wdata = cnt_q + COUNT_W'(1);
               sum_in    = sum_ff + SUM_W'({cnt_q, 1'b1});
            end
            state_in = S_PLAN;
            if (clr_ff && last_ff) begin
               clr_in   = 1'b0;
               sum_in   = '0;
               wl_in    = '0;
               wr_in    = '0;
               empty_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = bad_ff ? '0 : sum_ff;
               rsp_bad_in   = bad_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         init_addr_ff <= '0;
         empty_ff     <= 1'b1;
         clr_ff       <= 1'b0;
         last_ff      <= 1'b0;
         bad_ff       <= 1'b0;
         wl_ff        <= '0;
         wr_ff        <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_addr_ff <= init_addr_in;
         empty_ff     <= empty_in;
         clr_ff       <= clr_in;
         last_ff      <= last_in;
         bad_ff       <= bad_in;
         wl_ff        <= wl_in;
         wr_ff        <= wr_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      drop_ff    <= drop_in;
      l_ff       <= l_in;
      r_ff       <= r_in;
      bin_ff     <= bin_in;
      rsp_sum_ff <= rsp_sum_in;
      rsp_bad_ff <= rsp_bad_in;
   end

   // array of value bins
   always_ff @(posedge clock) begin
      if (arr_we) begin
         array_mem[arr_waddr] <= arr_wdata;
      end
      if (arr_re) begin
         arr_q <= array_mem[arr_raddr];
      end
   end

   // count per value bin
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         count_mem[cnt_waddr] <= cnt_wdata;
      end
      if (cnt_re) begin
         cnt_q <= count_mem[cnt_raddr];
      end
   end

endmodule

// ===== design/rssc_checker.sv =====
// port-level checks for range_sum_of_squared_counts, bound to the top level
// depends on rssc_pkg

module rssc_checker
   import rssc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   // response holds while stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response dropped or changed while stalled");

   // a bad range carries a zero sum
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("bad range response with nonzero sum");

   // no response straight out of reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // count sweep keeps requests out right after reset
   assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request taken during count sweep");

endmodule

bind range_sum_of_squared_counts rssc_checker u_checker (.*);

// ===== sim/testbench.sv =====
// self-checking testbench for range_sum_of_squared_counts: loads, queries and clears
// are checked against a window model kept here; depends on rssc_pkg and the design

module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import rssc_pkg::*;

   localparam int unsigned FIELD_MAX = (1 << FIELD_W) - 1;
   localparam int unsigned MAX_FILL  = 96;
   localparam int          SETTLE    = 3 * MAX_FILL + 100;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef struct {
      logic [KIND_W-1:0]  kind;
      logic [FIELD_W-1:0] position;
      logic [FIELD_W-1:0] element_value;
      logic [FIELD_W-1:0] range_left;
      logic [FIELD_W-1:0] range_right;
   } request_type;

   typedef struct {
      logic [SUM_W-1:0] square_sum;
      logic             bad_range;
   } answer_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [KIND_W-1:0]     req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [LEN_W-1:0]      csr_wdata  = '0;

   range_sum_of_squared_counts dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("range_sum_of_squared_counts regression: fail");
      $finish;
   end

   request_type req_backlog[$];
   answer_type  sums_due[$];
   int unsigned req_planned, req_taken, sums_seen, fail_count;

   // window model
   bit [FIELD_W-1:0] elem_mem [ARRAY_DEPTH_DEFAULT];
   bit [COUNT_W-1:0] value_tally [VALUE_COUNT_DEFAULT];
   bit [SUM_W-1:0]   window_sum;
   int unsigned      window_lo, window_hi, length_reg;
   bit               window_void = 1'b1;

   function automatic int unsigned bin_at(int unsigned pos);
      int unsigned v;
      v = (pos < ARRAY_DEPTH_DEFAULT) ? int'(elem_mem[pos]) : 0;
      if (v >= VALUE_COUNT_DEFAULT) v = VALUE_COUNT_DEFAULT - 1;
      return v;
   endfunction

   function automatic void count_in(int unsigned pos);
      int unsigned b;
      b = bin_at(pos);
      window_sum = window_sum + SUM_W'(2 * longint'(value_tally[b]) + 1);
      value_tally[b] = value_tally[b] + 1'b1;
   endfunction

   function automatic void count_out(int unsigned pos);
      int unsigned b;
      b = bin_at(pos);
      if (value_tally[b] == 0) return;
      window_sum = window_sum - SUM_W'(2 * longint'(value_tally[b]) - 1);
      value_tally[b] = value_tally[b] - 1'b1;
   endfunction

   function automatic void track_window(request_type rq);
      int unsigned l, r, p;
      answer_type  a;
      l = rq.range_left;
      r = rq.range_right;
      case (rq.kind)
         KIND_LOAD: begin
            if (window_void && rq.position < ARRAY_DEPTH_DEFAULT)
               elem_mem[rq.position] = rq.element_value;
         end
         KIND_CLEAR: begin
            if (!window_void)
               for (p = window_lo; p <= window_hi; p++) count_out(p);
            window_sum  = '0;
            window_lo   = 0;
            window_hi   = 0;
            window_void = 1'b1;
         end
         KIND_QUERY: begin
            if (l > r || r >= length_reg || r >= ARRAY_DEPTH_DEFAULT) begin
               a.square_sum = '0;
               a.bad_range  = 1'b1;
            end else begin
               if (window_void) begin
                  for (p = l; p <= r; p++) count_in(p);
                  window_lo   = l;
                  window_hi   = r;
                  window_void = 1'b0;
               end else begin
                  while (window_lo > l) begin
                     window_lo--;
                     count_in(window_lo);
                  end
                  while (window_hi < r) begin
                     window_hi++;
                     count_in(window_hi);
                  end
                  while (window_lo < l) begin
                     count_out(window_lo);
                     window_lo++;
                  end
                  while (window_hi > r) begin
                     count_out(window_hi);
                     window_hi--;
                  end
               end
               a.square_sum = window_sum;
               a.bad_range  = 1'b0;
            end
            sums_due.push_back(a);
         end
         default: ;
      endcase
   endfunction

   // stimulus planning: loaded positions form the prefix 0..plan_fill-1
   int unsigned plan_fill, plan_len;
   bit          plan_void = 1'b1;

   function automatic void add_item(logic [KIND_W-1:0] k, int unsigned a, int unsigned b);
      request_type rq;
      rq.kind          = k;
      rq.position      = FIELD_W'($urandom_range(FIELD_MAX));
      rq.element_value = FIELD_W'($urandom_range(FIELD_MAX));
      rq.range_left    = FIELD_W'($urandom_range(FIELD_MAX));
      rq.range_right   = FIELD_W'($urandom_range(FIELD_MAX));
      case (k)
         KIND_LOAD: begin
            rq.position      = FIELD_W'(a);
            rq.element_value = FIELD_W'(b);
            if (plan_void && a == plan_fill) plan_fill++;
         end
         KIND_QUERY: begin
            rq.range_left  = FIELD_W'(a);
            rq.range_right = FIELD_W'(b);
            if (a <= b && b < plan_len) plan_void = 1'b0;
         end
         KIND_CLEAR: plan_void = 1'b1;
         default: ;
      endcase
      req_backlog.push_back(rq);
      req_planned++;
   endfunction

   function automatic int unsigned pick_value();
      return ($urandom_range(2) == 0) ? $urandom_range(FIELD_MAX) : $urandom_range(7);
   endfunction

   task automatic wait_idle();
      do @(posedge clock);
      while (req_taken != req_planned || sums_due.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_length(int unsigned value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_wdata <= LEN_W'(value);
      do @(posedge clock);
      while (!csr_ready);
      csr_valid  <= 1'b0;
      length_reg = value;
      plan_len   = value;
   endtask

   task automatic random_phase(int unsigned n);
      int unsigned pick, top, l, r, p;
      add_item(KIND_CLEAR, 0, 0);
      repeat ($urandom_range(24, 4)) begin
         p = (plan_fill < MAX_FILL) ? plan_fill : $urandom_range(MAX_FILL - 1);
         add_item(KIND_LOAD, p, pick_value());
      end
      repeat (n) begin
         pick = $urandom_range(99);
         top  = (plan_fill < plan_len) ? plan_fill : plan_len;
         if (pick < 15) begin
            case ($urandom_range(9))
               0: p = $urandom_range(FIELD_MAX);
               1, 2, 3: p = (plan_fill == 0) ? 0 : $urandom_range(plan_fill - 1);
               default: p = (plan_fill < MAX_FILL) ? plan_fill : $urandom_range(MAX_FILL - 1);
            endcase
            add_item(KIND_LOAD, p, pick_value());
         end else if (pick < 22) begin
            add_item(KIND_CLEAR, 0, 0);
         end else if (pick < 24) begin
            add_item(KIND_UNUSED, 0, 0);
         end else if (pick < 32 || top == 0) begin
            if (plan_len > FIELD_MAX || $urandom_range(1) == 0) begin
               r = $urandom_range(FIELD_MAX - 1);
               l = $urandom_range(FIELD_MAX, r + 1);
            end else begin
               r = $urandom_range(FIELD_MAX, plan_len);
               l = $urandom_range(r);
            end
            add_item(KIND_QUERY, l, r);
         end else begin
            l = $urandom_range(top - 1);
            r = $urandom_range(top - 1, l);
            add_item(KIND_QUERY, l, r);
         end
      end
   endtask

   initial begin
      int unsigned start_vals[8];
      start_vals = '{0, FIELD_MAX, 5, 5, 5, FIELD_MAX, 0, 3};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // zero length after reset, so this query is out of range
      add_item(KIND_QUERY, 0, 0);
      for (int i = 0; i < 8; i++) add_item(KIND_LOAD, i, start_vals[i]);
      add_item(KIND_UNUSED, 0, 0);
      write_length(8);
      add_item(KIND_QUERY, 0, 7);
      // window busy, load dropped
      add_item(KIND_LOAD, 2, 9);
      add_item(KIND_QUERY, 2, 4);
      add_item(KIND_QUERY, 1, 6);
      add_item(KIND_QUERY, 5, 3);
      add_item(KIND_QUERY, 0, 8);
      add_item(KIND_QUERY, FIELD_MAX, FIELD_MAX);
      add_item(KIND_QUERY, 4, 4);
      add_item(KIND_CLEAR, 0, 0);
      add_item(KIND_CLEAR, 0, 0);
      add_item(KIND_LOAD, FIELD_MAX, FIELD_MAX);
      add_item(KIND_QUERY, 0, 0);
      add_item(KIND_CLEAR, 0, 0);
      write_length(ARRAY_DEPTH_DEFAULT);
      add_item(KIND_QUERY, FIELD_MAX, FIELD_MAX);
      add_item(KIND_QUERY, FIELD_MAX, 0);
      add_item(KIND_CLEAR, 0, 0);
      write_length(FIELD_MAX);
      add_item(KIND_QUERY, FIELD_MAX, FIELD_MAX);

      random_phase(100);
      write_length(1);
      random_phase(50);
      write_length(64);
      random_phase(120);
      write_length(0);
      random_phase(40);
      write_length(ARRAY_DEPTH_DEFAULT);
      random_phase(140);
      write_length(23);
      random_phase(90);
      write_length(MAX_FILL);
      random_phase(140);

      wait_idle();
      if (fail_count == 0)
         $display("range_sum_of_squared_counts regression: pass");
      else
         $display("range_sum_of_squared_counts regression: fail");
      $finish;
   end

   // request driver
   request_type shown;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            track_window(shown);
            req_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_backlog.size() != 0 &&
                ((req_taken >= 300 && req_taken < 450) || $urandom_range(99) >= 27)) begin
               shown = req_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {{(REQ_DATA_W - 4 * FIELD_W){1'b0}}, shown.range_right,
                              shown.range_left, shown.element_value, shown.position};
               req_tuser  <= shown.kind;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   answer_type  want;
   int unsigned hold_left;
   bit          held_once;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (sums_due.size() == 0) begin
               $error("unexpected response: square_sum %0d bad_range %0b",
                      rsp_tdata[SUM_W-1:0], rsp_tuser);
               fail_count++;
            end else begin
               want = sums_due.pop_front();
               if (rsp_tdata[SUM_W-1:0] !== want.square_sum) begin
                  $error("square_sum: expected %0d, actual %0d",
                         want.square_sum, rsp_tdata[SUM_W-1:0]);
                  fail_count++;
               end
               if (rsp_tuser !== want.bad_range) begin
                  $error("bad_range: expected %0b, actual %0b", want.bad_range, rsp_tuser);
                  fail_count++;
               end
            end
            sums_seen++;
         end
         // one long hold-off so the block backs up into req_tready
         if (!held_once && sums_seen >= 60 && req_backlog.size() > 10) begin
            held_once = 1'b1;
            hold_left = 1000;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (sums_seen >= 150 && sums_seen < 230) || $urandom_range(99) >= 27;
         end
      end
   end

endmodule
